@@ hw/rtl/ant_colony_pheromone_engine_top_defines.svh @@
// ============================================================================
// Assertion macros for the ant colony pheromone engine
// Shared property forms for the port-level checker.
// ============================================================================
`ifndef ANT_COLONY_PHEROMONE_ENGINE_TOP_DEFINES_SVH
`define ANT_COLONY_PHEROMONE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define ACPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication, off while reset is held
`define ACPE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port check failed");

// Next-cycle implication that also watches reset itself
`define ACPE_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

@@ hw/rtl/acpe_pkg.sv @@
// ============================================================================
// acpe_pkg
// Shared constants, codes and controller/datapath interface types.
// ============================================================================
package acpe_pkg;

    // Table geometry
    localparam int MAX_JOBS    = 16;
    localparam int MACHINES    = 3;
    localparam int ROUND_SLOTS = 16;
    localparam int TBL_DEPTH   = MACHINES * (MAX_JOBS + 1) * MAX_JOBS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int SLOT_AW     = $clog2(ROUND_SLOTS);
    localparam int CNT_W       = SLOT_AW + 1;

    // Field widths
    localparam int EXP_W  = 3;
    localparam int EVAP_W = 17;
    localparam int WORD_W = 32;
    localparam int TIME_W = 16;
    localparam int MKS_W  = 24;
    localparam int RND_W  = 31;
    localparam int POS_W  = 4;
    localparam int POW_W  = 41;
    localparam int WGT_W  = 24;
    localparam int IN_W   = 88;
    localparam int OUT_W  = 40;

    // Arithmetic constants
    localparam logic [POW_W-1:0]  POW_CAP    = 41'h100_0000_0000;
    localparam logic [EVAP_W-1:0] FIX_ONE    = 17'h1_0000;
    localparam logic [WGT_W-1:0]  WEIGHT_MAX = 24'hFF_FFFF;
    localparam logic [WORD_W-1:0] TAU_LIMIT  = 32'd65536000;

    // Item kinds
    localparam logic MODE_CAND  = 1'b0;
    localparam logic MODE_REINF = 1'b1;

    typedef enum logic [1:0] {
        CFG_TAU_EXP  = 2'd0,
        CFG_TIME_EXP = 2'd1,
        CFG_EVAP     = 2'd2,
        CFG_DEPOSIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_RECIP = 2'd0,
        DIV_MOD   = 2'd1,
        DIV_DEP   = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     ld_item;
        logic     tbl_rd;
        logic     ld_tau;
        logic     tp_lo;
        logic     tp_hi;
        logic     tm_init;
        logic     tm_lo;
        logic     tm_hi;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_recip;
        logic     ld_weight;
        logic     accum;
        logic     pos_init;
        logic     ld_choice;
        logic     sc_rd;
        logic     sc_take;
        logic     sc_next;
        logic     rf_chk;
        logic     ld_add;
        logic     rf_sum;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic mode;
        logic last;
        logic tp_more;
        logic tm_more;
        logic p_zero;
        logic sum_zero;
        logic div_busy;
        logic upd_ok;
        logic sc_more;
        logic sc_hit;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/ant_colony_pheromone_engine_top.sv @@
// ============================================================================
// ant_colony_pheromone_engine_top
// Pheromone table with roulette-wheel job selection and edge reinforcement.
// ============================================================================
// Items are handled one at a time. After reset the 816-entry pheromone table
// is swept to zero, one entry per cycle, and s_tready stays low during the
// sweep. For a candidate item each power step passes through a low-half and a
// high-half step on the shared 32x32 multiplier, and the reciprocal runs on
// the shared one-bit-per-cycle divider. The last candidate of a round adds
// the modulo on the same divider and a scan of the cumulative weights. A
// reinforce item adds the deposit division. A finished result waits in the
// output register without holding up the next item.
module ant_colony_pheromone_engine_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: machine[1:0], prev_is_start[2], prev_job[6:3], next_job[10:7],
    //          op_time[26:11], makespan[50:27], random_value[81:51], zero fill
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [acpe_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tuser,   // mode
    input  logic                        s_tlast,
    // m_tdata: chosen_position[3:0], level[35:4], zero fill
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [acpe_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tuser,   // is_choice
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  acpe_pkg::cfg_idx_t          cfg_index,
    input  logic [acpe_pkg::WORD_W-1:0] cfg_data
);
    import acpe_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    acpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    acpe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_wr    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

@@ hw/rtl/acpe_ram.sv @@
// ============================================================================
// acpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module acpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/acpe_div.sv @@
// ============================================================================
// acpe_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ============================================================================
module acpe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [acpe_pkg::WORD_W-1:0] dividend,
    input  logic [acpe_pkg::POW_W-1:0]  divisor,
    output logic                       busy,
    output logic [acpe_pkg::WORD_W-1:0] quot,
    output logic [acpe_pkg::POW_W-1:0]  rem
);
    import acpe_pkg::*;

    localparam int STEPS = WORD_W;
    localparam int SC_W  = $clog2(STEPS + 1);

    logic [WORD_W-1:0] q_reg;
    logic [POW_W-1:0]  r_reg;
    logic [POW_W-1:0]  d_reg;
    logic [SC_W-1:0]   cnt_reg;
    logic              busy_reg;
    logic [POW_W:0]    trial;
    logic [POW_W:0]    diff;
    logic              ge;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_reg, q_reg[WORD_W-1]};
        ge    = trial >= {1'b0, d_reg};
        diff  = trial - {1'b0, d_reg};
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= SC_W'(STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - SC_W'(1);
            if (cnt_reg == SC_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            r_reg <= ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
            q_reg <= {q_reg[WORD_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

@@ hw/rtl/acpe_ctrl.sv @@
// ============================================================================
// acpe_ctrl
// Sequencer: steps the datapath through clearing, weighting, roulette and
// reinforcement.
// ============================================================================
module acpe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  acpe_pkg::status_t st,
    output acpe_pkg::cmd_t    cmd
);
    import acpe_pkg::*;

    typedef enum logic [21:0] {
        ST_CLEAR   = 22'd1 << 0,
        ST_IDLE    = 22'd1 << 1,
        ST_READ    = 22'd1 << 2,
        ST_TAU     = 22'd1 << 3,
        ST_TP_CHK  = 22'd1 << 4,
        ST_TP_LO   = 22'd1 << 5,
        ST_TP_HI   = 22'd1 << 6,
        ST_TM_CHK  = 22'd1 << 7,
        ST_TM_LO   = 22'd1 << 8,
        ST_TM_HI   = 22'd1 << 9,
        ST_RECIP   = 22'd1 << 10,
        ST_RECIP_W = 22'd1 << 11,
        ST_WEIGHT  = 22'd1 << 12,
        ST_ACCUM   = 22'd1 << 13,
        ST_MOD     = 22'd1 << 14,
        ST_MOD_W   = 22'd1 << 15,
        ST_SC_RD   = 22'd1 << 16,
        ST_SC_CMP  = 22'd1 << 17,
        ST_RF_CHK  = 22'd1 << 18,
        ST_RF_W    = 22'd1 << 19,
        ST_RF_SUM  = 22'd1 << 20,
        ST_EMIT    = 22'd1 << 21
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_item = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.tbl_rd = 1'b1;
                state_next = ST_TAU;
            end
            ST_TAU: begin
                cmd.ld_tau = 1'b1;
                state_next = (st.mode == MODE_REINF) ? ST_RF_CHK : ST_TP_CHK;
            end
            ST_TP_CHK: begin
                if (st.tp_more) begin
                    state_next = ST_TP_LO;
                end else begin
                    cmd.tm_init = 1'b1;
                    state_next  = ST_TM_CHK;
                end
            end
            ST_TP_LO: begin
                cmd.tp_lo  = 1'b1;
                state_next = ST_TP_HI;
            end
            ST_TP_HI: begin
                cmd.tp_hi  = 1'b1;
                state_next = ST_TP_CHK;
            end
            ST_TM_CHK: begin
                state_next = st.tm_more ? ST_TM_LO : ST_RECIP;
            end
            ST_TM_LO: begin
                cmd.tm_lo  = 1'b1;
                state_next = ST_TM_HI;
            end
            ST_TM_HI: begin
                cmd.tm_hi  = 1'b1;
                state_next = ST_TM_CHK;
            end
            ST_RECIP: begin
                if (st.p_zero) begin
                    cmd.ld_recip = 1'b1;
                    state_next   = ST_WEIGHT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_RECIP;
                    state_next    = ST_RECIP_W;
                end
            end
            ST_RECIP_W: begin
                if (!st.div_busy) begin
                    cmd.ld_recip = 1'b1;
                    state_next   = ST_WEIGHT;
                end
            end
            ST_WEIGHT: begin
                cmd.ld_weight = 1'b1;
                state_next    = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = st.last ? ST_MOD : ST_IDLE;
            end
            ST_MOD: begin
                cmd.pos_init = 1'b1;
                if (st.sum_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MOD;
                    state_next    = ST_MOD_W;
                end
            end
            ST_MOD_W: begin
                if (!st.div_busy) begin
                    cmd.ld_choice = 1'b1;
                    state_next    = ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                if (st.sc_more) begin
                    cmd.sc_rd  = 1'b1;
                    state_next = ST_SC_CMP;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SC_CMP: begin
                if (st.sc_hit) begin
                    cmd.sc_take = 1'b1;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.sc_next = 1'b1;
                    state_next  = ST_SC_RD;
                end
            end
            ST_RF_CHK: begin
                cmd.rf_chk = 1'b1;
                if (st.upd_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DEP;
                    state_next    = ST_RF_W;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_RF_W: begin
                if (!st.div_busy) begin
                    cmd.ld_add = 1'b1;
                    state_next = ST_RF_SUM;
                end
            end
            ST_RF_SUM: begin
                cmd.rf_sum = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ hw/rtl/acpe_dp.sv @@
// ============================================================================
// acpe_dp
// Datapath: item and configuration registers, pheromone and round memories,
// shared multiplier and divider, result register.
// ============================================================================
module acpe_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [acpe_pkg::IN_W-1:0]  s_tdata,
    input  logic                       s_tuser,
    input  logic                       s_tlast,
    input  logic                       cfg_wr,
    input  acpe_pkg::cfg_idx_t         cfg_index,
    input  logic [acpe_pkg::WORD_W-1:0] cfg_data,
    input  acpe_pkg::cmd_t             cmd,
    output acpe_pkg::status_t          st,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [acpe_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tuser
);
    import acpe_pkg::*;

    // Configuration
    logic [EXP_W-1:0]  tau_exp_reg;
    logic [EXP_W-1:0]  time_exp_reg;
    logic [EVAP_W-1:0] evap_reg;
    logic [WORD_W-1:0] deposit_reg;

    // Item
    logic              mode_reg;
    logic              last_reg;
    logic              ok_reg;
    logic [TBL_AW-1:0] idx_reg;
    logic [TIME_W-1:0] t_reg;
    logic [MKS_W-1:0]  mks_reg;
    logic [RND_W-1:0]  rnd_reg;

    // Working values
    logic [WORD_W-1:0]   tau_reg;
    logic [POW_W-1:0]    acc_reg;
    logic [POW_W-1:0]    p_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [POW_W-1:0]    recip_reg;
    logic [WGT_W-1:0]    w_reg;
    logic [WORD_W-1:0]   choice_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WORD_W-1:0]   keep_reg;
    logic [WORD_W-1:0]   add_reg;
    logic [WORD_W-1:0]   level_reg;
    logic [EXP_W-1:0]    exp_cnt_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [WORD_W-1:0]   sum_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [TBL_AW-1:0]   clr_addr_reg;

    // Result register
    logic              m_valid_reg;
    logic              m_user_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [WORD_W-1:0] m_level_reg;

    // Item unpack and table index
    logic [1:0]        in_mach;
    logic              in_start;
    logic [3:0]        in_prev;
    logic [3:0]        in_next;
    int                row_i;
    logic [TBL_AW-1:0] idx_new;
    logic              ok_new;

    always_comb begin
        in_mach  = s_tdata[1:0];
        in_start = s_tdata[2];
        in_prev  = s_tdata[6:3];
        in_next  = s_tdata[10:7];
        row_i    = in_start ? MAX_JOBS : int'(in_prev);
        idx_new  = TBL_AW'((int'(in_mach) * (MAX_JOBS + 1) + row_i) * MAX_JOBS
                   + int'(in_next));
        ok_new   = (int'(in_mach) < MACHINES) && (int'(in_next) < MAX_JOBS)
                   && (in_start || (int'(in_prev) < MAX_JOBS));
    end

    // Shared multiplier, operands picked by the step in progress
    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_b;
    logic [2*WORD_W-1:0] mul_out;
    logic [EVAP_W-1:0]   ev_cl;
    logic [EVAP_W-1:0]   factor;

    always_comb begin
        ev_cl  = (evap_reg > FIX_ONE) ? FIX_ONE : evap_reg;
        factor = FIX_ONE - ev_cl;
        if (cmd.tp_lo) begin
            mul_a = acc_reg[WORD_W-1:0];
            mul_b = tau_reg;
        end else if (cmd.tp_hi) begin
            mul_a = WORD_W'(acc_reg[POW_W-1:WORD_W]);
            mul_b = tau_reg;
        end else if (cmd.tm_lo) begin
            mul_a = p_reg[WORD_W-1:0];
            mul_b = WORD_W'(t_reg);
        end else if (cmd.tm_hi) begin
            mul_a = WORD_W'(p_reg[POW_W-1:WORD_W]);
            mul_b = WORD_W'(t_reg);
        end else begin
            mul_a = tau_reg;
            mul_b = WORD_W'(factor);
        end
        mul_out = mul_a * mul_b;
    end

    // Combine partial products, cap powers
    logic [73:0]      full;
    logic [57:0]      tp_sh;
    logic [POW_W-1:0] acc_new;
    logic [POW_W-1:0] p_new;

    always_comb begin
        full    = {10'b0, prod_reg} + {mul_out[41:0], 32'b0};
        tp_sh   = full[73:16];
        acc_new = (tp_sh > 58'(POW_CAP)) ? POW_CAP : tp_sh[POW_W-1:0];
        p_new   = (full > 74'(POW_CAP)) ? POW_CAP : full[POW_W-1:0];
    end

    // Weight: 1 + floor(100 * s / 2^16), saturated
    logic [POW_W:0]   s_sum;
    logic [48:0]      s_ext;
    logic [48:0]      s_x100;
    logic [32:0]      w_raw;
    logic [WGT_W-1:0] w_new;

    always_comb begin
        s_sum  = {1'b0, acc_reg} + {1'b0, recip_reg};
        s_ext  = 49'(s_sum);
        s_x100 = (s_ext << 6) + (s_ext << 5) + (s_ext << 2);
        w_raw  = s_x100[48:16];
        w_new  = (w_raw >= 33'(WEIGHT_MAX)) ? WEIGHT_MAX : WGT_W'(w_raw + 33'd1);
    end

    // Running sum and round slot
    logic [WORD_W:0]   ns_sum;
    logic [WORD_W-1:0] sum_new;
    logic              slot_free;

    always_comb begin
        ns_sum    = {1'b0, sum_reg} + (WORD_W + 1)'(w_reg);
        sum_new   = ns_sum[WORD_W] ? '1 : ns_sum[WORD_W-1:0];
        slot_free = count_reg < CNT_W'(ROUND_SLOTS);
    end

    // Reinforced level
    logic [WORD_W+1:0] tot;
    logic [WORD_W-1:0] level_new;

    always_comb begin
        tot       = (WORD_W + 2)'(tau_reg) + (WORD_W + 2)'(keep_reg)
                    + (WORD_W + 2)'(add_reg);
        level_new = (tot[WORD_W+1:WORD_W] != 2'b00) ? '1 : tot[WORD_W-1:0];
    end

    // Divider operands
    logic              div_busy;
    logic [WORD_W-1:0] div_q;
    logic [POW_W-1:0]  div_r;
    logic [WORD_W-1:0] div_dvd;
    logic [POW_W-1:0]  div_dvs;

    always_comb begin
        case (cmd.div_sel)
            DIV_RECIP: begin
                div_dvd = WORD_W'(FIX_ONE);
                div_dvs = p_reg;
            end
            DIV_MOD: begin
                div_dvd = WORD_W'(rnd_reg);
                div_dvs = POW_W'(sum_reg);
            end
            DIV_DEP: begin
                div_dvd = deposit_reg;
                div_dvs = POW_W'(mks_reg);
            end
            default: begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    acpe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Pheromone table, cleared by a sweep after reset
    logic [WORD_W-1:0] tbl_rdata;

    acpe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (cmd.clr_step | cmd.rf_sum),
        .waddr (cmd.clr_step ? clr_addr_reg : idx_reg),
        .wdata (cmd.clr_step ? '0 : level_new),
        .re    (cmd.tbl_rd),
        .raddr (idx_reg),
        .rdata (tbl_rdata)
    );

    // Cumulative weights of the open round
    logic [WORD_W-1:0] cum_rdata;

    acpe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROUND_SLOTS)
    ) u_cum (
        .aclk  (aclk),
        .we    (cmd.accum & slot_free),
        .waddr (count_reg[SLOT_AW-1:0]),
        .wdata (sum_new),
        .re    (cmd.sc_rd),
        .raddr (k_reg[SLOT_AW-1:0]),
        .rdata (cum_rdata)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_exp_reg  <= EXP_W'(1);
            time_exp_reg <= EXP_W'(1);
            evap_reg     <= EVAP_W'(6554);
            deposit_reg  <= WORD_W'(65536);
            clr_addr_reg <= '0;
            exp_cnt_reg  <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    CFG_TAU_EXP:  tau_exp_reg  <= cfg_data[EXP_W-1:0];
                    CFG_TIME_EXP: time_exp_reg <= cfg_data[EXP_W-1:0];
                    CFG_EVAP:     evap_reg     <= cfg_data[EVAP_W-1:0];
                    CFG_DEPOSIT:  deposit_reg  <= cfg_data;
                    default:      deposit_reg  <= deposit_reg;
                endcase
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + TBL_AW'(1);
            end
            // Exponent loops share one counter
            if (cmd.ld_tau || cmd.tm_init) begin
                exp_cnt_reg <= '0;
            end else if (cmd.tp_hi || cmd.tm_hi) begin
                exp_cnt_reg <= exp_cnt_reg + EXP_W'(1);
            end
            if (cmd.accum && slot_free) begin
                sum_reg   <= sum_new;
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.ld_choice) begin
                k_reg <= '0;
            end else if (cmd.sc_next) begin
                k_reg <= k_reg + CNT_W'(1);
            end
            // Close the round when its choice goes out
            if (cmd.emit && (mode_reg == MODE_CAND)) begin
                count_reg <= '0;
                sum_reg   <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            mode_reg <= s_tuser;
            last_reg <= s_tlast;
            ok_reg   <= ok_new;
            idx_reg  <= idx_new;
            t_reg    <= s_tdata[26:11];
            mks_reg  <= s_tdata[50:27];
            rnd_reg  <= s_tdata[81:51];
        end
        if (cmd.ld_tau) begin
            tau_reg <= ok_reg ? tbl_rdata : '0;
            acc_reg <= POW_W'(FIX_ONE);
        end
        if (cmd.tp_lo || cmd.tm_lo) begin
            prod_reg <= mul_out;
        end
        if (cmd.tp_hi) begin
            acc_reg <= acc_new;
        end
        if (cmd.tm_init) begin
            p_reg <= POW_W'(1);
        end else if (cmd.tm_hi) begin
            p_reg <= p_new;
        end
        if (cmd.ld_recip) begin
            recip_reg <= (p_reg == '0) ? POW_CAP : POW_W'(div_q);
        end
        if (cmd.ld_weight) begin
            w_reg <= w_new;
        end
        if (cmd.pos_init) begin
            pos_reg <= (count_reg == '0) ? '0 : POS_W'(count_reg - CNT_W'(1));
        end else if (cmd.sc_take) begin
            pos_reg <= k_reg[POS_W-1:0];
        end
        if (cmd.ld_choice) begin
            choice_reg <= div_r[WORD_W-1:0];
        end
        if (cmd.rf_chk) begin
            level_reg <= ok_reg ? tau_reg : '0;
            keep_reg  <= mul_out[47:16];
        end
        if (cmd.ld_add) begin
            add_reg <= (mks_reg == '0) ? '1 : div_q;
        end
        if (cmd.rf_sum) begin
            level_reg <= level_new;
        end
        if (cmd.emit) begin
            m_user_reg  <= (mode_reg == MODE_CAND);
            m_pos_reg   <= (mode_reg == MODE_CAND) ? pos_reg : '0;
            m_level_reg <= (mode_reg == MODE_CAND) ? '0 : level_reg;
        end
    end

    // Status to the sequencer
    always_comb begin
        st.clr_done = clr_addr_reg == TBL_AW'(TBL_DEPTH - 1);
        st.mode     = mode_reg;
        st.last     = last_reg;
        st.tp_more  = exp_cnt_reg < tau_exp_reg;
        st.tm_more  = exp_cnt_reg < time_exp_reg;
        st.p_zero   = p_reg == '0;
        st.sum_zero = sum_reg == '0;
        st.div_busy = div_busy;
        st.upd_ok   = ok_reg && (tau_reg <= TAU_LIMIT);
        st.sc_more  = k_reg < count_reg;
        st.sc_hit   = cum_rdata > choice_reg;
        st.out_free = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {4'b0, m_level_reg, m_pos_reg};
endmodule

@@ hw/rtl/acpe_checker.sv @@
// ============================================================================
// acpe_checker
// Port-level checks of the engine, bound to the top level.
// ============================================================================
`include "ant_colony_pheromone_engine_top_defines.svh"

module acpe_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [acpe_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);
    import acpe_pkg::*;

    // Hold a stalled result beat
    `ACPE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Take no second item right after one is accepted
    `ACPE_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A roulette choice carries no level
    `ACPE_ASSERT_IMP(a_choice_clean, aclk, aresetn, m_tvalid && m_tuser, m_tdata[OUT_W-1:POS_W] == '0)
    // A reinforce report carries no position
    `ACPE_ASSERT_IMP(a_report_clean, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[POS_W-1:0] == '0)
    // Stay quiet on both sides after reset is sampled low
    `ACPE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid && !s_tready)
endmodule

bind ant_colony_pheromone_engine_top acpe_checker u_acpe_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Pheromone engine testbench
// Drives candidate rounds and tour-edge reinforcements over the stream ports,
// predicts most results with a local copy of the pheromone table, takes fixed
// expectations for some directed items and checks each output beat in order,
// under several register settings and random idling on both sides.
// ============================================================================
module testbench;
    import acpe_pkg::*;

    typedef struct {
        logic        mode;
        logic [1:0]  machine;
        logic        from_start;
        logic [3:0]  prev_job;
        logic [3:0]  next_job;
        logic [15:0] op_time;
        logic [23:0] makespan;
        logic        last;
        logic [30:0] rnd;
    } job_item_t;

    typedef struct {
        logic        is_choice;
        logic [3:0]  pos;
        logic [31:0] level;
    } engine_out_t;

    typedef struct {
        job_item_t   item;
        logic        typed;
        engine_out_t want;
    } dir_row_t;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE       = 300;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index = CFG_TAU_EXP;
    logic [WORD_W-1:0]   cfg_data = '0;

    ant_colony_pheromone_engine_top dut (.*);

    always #2 aclk = ~aclk;

    // Shadow state of the engine
    logic [31:0] tau_tbl [TBL_DEPTH];
    logic [31:0] cum_wt [ROUND_SLOTS];
    int unsigned cand_cnt;
    logic [31:0] round_sum;
    logic [2:0]  tau_exp_r = 3'd1;
    logic [2:0]  time_exp_r = 3'd1;
    logic [16:0] evap_r = 17'd6554;
    logic [31:0] deposit_r = 32'd65536;

    engine_out_t pending_q[$];
    int unsigned n_accepted, n_results, n_cfg, n_fail, n_rounds, n_reinf;
    int unsigned cycles;
    bit          calm, hold_go, hold_on;
    bit          cur_typed;
    engine_out_t cur_want;
    job_item_t   cur_item;

    function automatic longint unsigned tau_pow(longint unsigned tau, int n);
        longint unsigned acc;
        acc = 64'd65536;
        for (int i = 0; i < n; i++) begin
            if (tau != 0 && acc > 64'hFFFF_FFFF_FFFF_FFFF / tau)
                acc = 64'd1 << 40;
            else
                acc = (acc * tau) >> 16;
            if (acc > (64'd1 << 40))
                acc = 64'd1 << 40;
        end
        return acc;
    endfunction

    function automatic longint unsigned time_recip(longint unsigned t, int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * t;
            if (p > (64'd1 << 40))
                p = 64'd1 << 40;
        end
        if (p == 0)
            return 64'd1 << 40;
        return 64'd65536 / p;
    endfunction

    // Advance the shadow state by one item; return 1 when it yields a beat
    function automatic bit engine_step(job_item_t it, output engine_out_t res);
        int unsigned     row, idx, pos;
        bit              ok;
        longint unsigned tau, s, w, ns, lvl, ev, keep, add, pick;
        row = it.from_start ? MAX_JOBS : it.prev_job;
        ok  = it.machine < MACHINES;
        idx = (it.machine * (MAX_JOBS + 1) + row) * MAX_JOBS + it.next_job;
        res = '{1'b0, 4'd0, 32'd0};
        if (it.mode == MODE_CAND) begin
            tau = ok ? tau_tbl[idx] : 0;
            s = tau_pow(tau, tau_exp_r) + time_recip(it.op_time, time_exp_r);
            w = 1 + ((100 * s) >> 16);
            if (w > WEIGHT_MAX)
                w = WEIGHT_MAX;
            if (cand_cnt < ROUND_SLOTS) begin
                ns = round_sum + w;
                round_sum = ns > 32'hFFFF_FFFF ? 32'hFFFF_FFFF : ns[31:0];
                cum_wt[cand_cnt] = round_sum;
                cand_cnt++;
            end
            if (!it.last)
                return 0;
            pos = cand_cnt ? cand_cnt - 1 : 0;
            if (round_sum != 0) begin
                pick = it.rnd % round_sum;
                for (int k = 0; k < cand_cnt; k++) begin
                    if (cum_wt[k] > pick) begin
                        pos = k;
                        break;
                    end
                end
            end
            cand_cnt  = 0;
            round_sum = 0;
            res.is_choice = 1'b1;
            res.pos = pos[3:0];
            return 1;
        end
        lvl = 0;
        if (ok) begin
            tau = tau_tbl[idx];
            lvl = tau;
            if (tau <= TAU_LIMIT) begin
                ev   = evap_r > 65536 ? 65536 : evap_r;
                keep = ((65536 - ev) * tau) >> 16;
                add  = it.makespan ? deposit_r / it.makespan : 64'hFFFF_FFFF;
                lvl  = tau + keep + add;
                if (lvl > 64'hFFFF_FFFF)
                    lvl = 64'hFFFF_FFFF;
                tau_tbl[idx] = lvl[31:0];
            end
        end
        res.level = lvl[31:0];
        return 1;
    endfunction

    function automatic dir_row_t row_of(logic mode, logic [1:0] m, logic st, logic [3:0] pj,
                                        logic [3:0] nj, logic [15:0] op, logic [23:0] mk,
                                        logic lst, logic [30:0] r, logic typed,
                                        logic ch, logic [3:0] ps, logic [31:0] lv);
        dir_row_t d;
        d.item  = '{mode, m, st, pj, nj, op, mk, lst, r};
        d.typed = typed;
        d.want  = '{ch, ps, lv};
        return d;
    endfunction

    // Input and config acceptance, predicted results queued here
    always @(posedge aclk) begin
        engine_out_t res;
        if (aresetn && s_tvalid && s_tready) begin
            n_accepted++;
            if (engine_step(cur_item, res))
                pending_q = {pending_q, (cur_typed ? cur_want : res)};
        end
        if (aresetn && cfg_valid && cfg_ready)
            n_cfg++;
    end

    // Compare each output beat with the oldest expectation
    always @(posedge aclk) begin
        engine_out_t w;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected beat: choice=%0b pos=%0d level=%h",
                             m_tuser, m_tdata[3:0], m_tdata[35:4]);
            end else begin
                w = pending_q.pop_front();
                if (m_tuser !== w.is_choice || m_tdata[3:0] !== w.pos ||
                    m_tdata[35:4] !== w.level) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: want choice=%0b pos=%0d level=%h, got %0b %0d %h",
                                 w.is_choice, w.pos, w.level,
                                 m_tuser, m_tdata[3:0], m_tdata[35:4]);
                end
            end
        end
    end

    // Output side: random stalls, calm stretch, and one long hold-off
    always @(negedge aclk) begin
        if (hold_on)
            m_tready = 1'b0;
        else if (calm)
            m_tready = 1'b1;
        else
            m_tready = ($urandom_range(0, 99) >= 26);
    end

    initial begin
        wait (hold_go);
        @(negedge aclk);
        hold_on = 1'b1;
        repeat (400) @(negedge aclk);
        hold_on = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(job_item_t it, bit typed = 0, engine_out_t want = '{0, 0, 0});
        int unsigned seen;
        calm = (n_accepted >= 450 && n_accepted < 650);
        if (n_accepted == 700)
            hold_go = 1'b1;
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        cur_item  = it;
        cur_typed = typed;
        cur_want  = want;
        s_tuser   = it.mode;
        s_tlast   = it.last;
        s_tdata   = '0;
        s_tdata[81:0] = {it.rnd, it.makespan, it.op_time, it.next_job,
                         it.prev_job, it.from_start, it.machine};
        s_tvalid  = 1'b1;
        seen = n_accepted;
        do @(negedge aclk); while (n_accepted == seen);
        s_tvalid = 1'b0;
        if (it.mode == MODE_REINF)
            n_reinf++;
        else if (it.last)
            n_rounds++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        int unsigned seen;
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        seen = n_cfg;
        do @(negedge aclk); while (n_cfg == seen);
        cfg_valid = 1'b0;
        case (idx)
            CFG_TAU_EXP:  tau_exp_r  = val[2:0];
            CFG_TIME_EXP: time_exp_r = val[2:0];
            CFG_EVAP:     evap_r     = val[16:0];
            CFG_DEPOSIT:  deposit_r  = val;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 16'd0;
        if (r < 45)
            return 16'($urandom_range(1, 20));
        return 16'($urandom_range(1, 16'hFFFF));
    endfunction

    function automatic logic [23:0] pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 24'd0;
        if (r < 40)
            return 24'($urandom_range(1, 64));
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    function automatic logic [1:0] pick_machine();
        return ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    // Mostly well-formed rounds and tour edges, with stray out-of-range items
    task automatic random_items(int unsigned count);
        job_item_t   it;
        int unsigned sent, k;
        sent = 0;
        while (sent < count) begin
            it.machine    = pick_machine();
            it.from_start = $urandom_range(0, 3) == 0;
            it.prev_job   = 4'($urandom_range(0, 15));
            it.rnd        = 31'($urandom);
            if ($urandom_range(0, 99) < 30) begin
                // reinforce a short run of tour edges
                k = $urandom_range(1, 4);
                repeat (k) begin
                    it.mode     = MODE_REINF;
                    it.next_job = ($urandom_range(0, 1)) ? 4'($urandom_range(0, 3))
                                                         : 4'($urandom_range(0, 15));
                    it.op_time  = 16'($urandom);
                    it.makespan = pick_span();
                    it.last     = ($urandom_range(0, 1) == 1);
                    send_item(it);
                    it.prev_job   = it.next_job;
                    it.from_start = 1'b0;
                    sent++;
                end
            end else begin
                // one roulette round, sometimes past the slot count
                k = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 18)
                                                : $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    it.mode     = MODE_CAND;
                    it.next_job = ($urandom_range(0, 1)) ? 4'($urandom_range(0, 3))
                                                         : 4'($urandom_range(0, 15));
                    it.op_time  = pick_time();
                    it.makespan = 24'($urandom);
                    it.last     = (i == k - 1);
                    it.rnd      = 31'($urandom);
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        dir_row_t    dir_q[$];
        logic [31:0] phase_cfg [5][4];
        for (int i = 0; i < TBL_DEPTH; i++)
            tau_tbl[i] = '0;
        cand_cnt  = 0;
        round_sum = '0;
        phase_cfg = '{'{2, 1, 6554, 65536 * 50},
                      '{0, 0, 0, 0},
                      '{7, 7, 65536, 32'hFFFF_FFFF},
                      '{3, 2, 32'h1_FFFF, 32'h0010_0000},
                      '{1, 3, 32768, 65536 * 8}};

        // Directed rows under the reset settings
        dir_q = {dir_q, row_of(MODE_CAND, 0, 1, 0, 0, 1, 0, 1, 0, 1, 1, 0, 0)};
        dir_q = {dir_q, row_of(MODE_REINF, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 65536)};
        dir_q = {dir_q, row_of(MODE_REINF, 0, 1, 0, 0, 0, 24'hFF_FFFF, 0, 0,
                               0, 0, 0, 0)};
        dir_q = {dir_q, row_of(MODE_REINF, 3, 0, 4, 5, 0, 7, 1, 0, 1, 0, 0, 0)};
        dir_q = {dir_q, row_of(MODE_REINF, 2, 0, 15, 15, 0, 0, 0, 0,
                               1, 0, 0, 32'hFFFF_FFFF)};
        dir_q = {dir_q, row_of(MODE_REINF, 2, 0, 15, 15, 0, 3, 0, 0,
                               1, 0, 0, 32'hFFFF_FFFF)};
        dir_q = {dir_q, row_of(MODE_CAND, 2, 0, 15, 15, 16'hFFFF, 0, 0, 0,
                               0, 0, 0, 0)};
        dir_q = {dir_q, row_of(MODE_CAND, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
        dir_q = {dir_q, row_of(MODE_CAND, 3, 0, 5, 9, 7, 0, 1, 31'h7FFF_FFFF,
                               0, 0, 0, 0)};
        for (int i = 0; i < 17; i++)
            dir_q = {dir_q, row_of(MODE_CAND, 0, 1, 0, i[3:0], 16'(i + 1), 0, i == 16,
                                   31'h5555_5555, 0, 0, 0, 0)};

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_q[i])
            send_item(dir_q[i].item, dir_q[i].typed, dir_q[i].want);

        for (int p = 0; p < 5; p++) begin
            drain();
            write_reg(CFG_TAU_EXP,  phase_cfg[p][0]);
            write_reg(CFG_TIME_EXP, phase_cfg[p][1]);
            write_reg(CFG_EVAP,     phase_cfg[p][2]);
            write_reg(CFG_DEPOSIT,  phase_cfg[p][3]);
            random_items(205);
        end
        drain();

        $display("covered %0d items: %0d roulette rounds, %0d edge updates, %0d beats",
                 n_accepted, n_rounds, n_reinf, n_results);
        $display("five register settings incl. extremes, %0d mismatches", n_fail);
        if (n_fail == 0 && pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
